// ----- hw/rtl/olapwm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Open-loop alignment PWM package
// Field layouts, fixed-point constants and the CORDIC arctangent table shared
// by the alignment PWM stage.
// ----------------------------------------------------------------------------
package olapwm_pkg;

  // Register indexes of the configuration port.
  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] REG_CURRENT_LIMIT = 1'b0;
  localparam logic [CfgAddrW-1:0] REG_BUS_VOLTAGE   = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [14:0] CurrentLimitRst = 15'd3000;
  localparam logic [15:0] BusVoltageRst   = 16'd24000;

  // Bus voltage floor and the value used at or below it.
  localparam logic [15:0] BusFloorMv   = 16'd1000;
  localparam logic [15:0] DefaultBusMv = 16'd24000;

  // Clamp of the d-axis voltage in millivolts.
  localparam logic signed [15:0] VdLimitMv = 16'sd3000;

  // CORDIC gain compensation and sqrt(3)/2, both Q16.
  localparam logic signed [17:0] CordicGainQ16 = 18'sd39797;
  localparam logic signed [17:0] HalfSqrt3Q16  = 18'sd56756;

  // Iteration counts.
  localparam int unsigned AtanEntries    = 24;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned IterW          = 5;
  localparam int unsigned DivBits        = 32;
  localparam int unsigned DivCntW        = 5;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [15:0]        align_angle;
    logic signed [15:0] align_voltage_mv;
    logic               align_request;
    logic               calibrating;
    logic               clear_trip;
    logic               currents_ok;
    logic signed [15:0] current_c_ma;
    logic signed [15:0] current_b_ma;
    logic signed [15:0] current_a_ma;
  } in_item_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic signed [12:0] applied_vd_mv;
    logic [15:0]        duty_phase_c;
    logic [15:0]        duty_phase_b;
    logic [15:0]        duty_phase_a;
    logic               pwm_off_event;
    logic               pwm_start_event;
    logic               pwm_active;
    logic               trip_latched;
    logic [15:0]        peak_current_ma;
  } res_item_t;

  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 88;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] atan_turn(input logic [IterW-1:0] idx);
    logic [29:0] val;
    unique case (idx)
      5'd0:    val = 30'd536870912;
      5'd1:    val = 30'd316933406;
      5'd2:    val = 30'd167458907;
      5'd3:    val = 30'd85004756;
      5'd4:    val = 30'd42667331;
      5'd5:    val = 30'd21354465;
      5'd6:    val = 30'd10679838;
      5'd7:    val = 30'd5340245;
      5'd8:    val = 30'd2670163;
      5'd9:    val = 30'd1335087;
      5'd10:   val = 30'd667544;
      5'd11:   val = 30'd333772;
      5'd12:   val = 30'd166886;
      5'd13:   val = 30'd83443;
      5'd14:   val = 30'd41722;
      5'd15:   val = 30'd20861;
      5'd16:   val = 30'd10430;
      5'd17:   val = 30'd5215;
      5'd18:   val = 30'd2608;
      5'd19:   val = 30'd1304;
      5'd20:   val = 30'd652;
      5'd21:   val = 30'd326;
      5'd22:   val = 30'd163;
      5'd23:   val = 30'd81;
      default: val = 30'd0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/open_loop_align_pwm_with_trip.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Open-loop alignment PWM stage with over-current trip
//
//   Channel  Direction  Content
//   s_axis   in         three phase currents, status flags, voltage, angle
//   m_axis   out        peak current, trip/PWM flags, three duties, applied vd
//   cfg      in         current limit (index 0), bus voltage (index 1)
//
// One item at a time. An item that drives the PWM runs CORDIC_STEPS rotation
// steps, with CORDIC_STEPS capped at 24: the CORDIC rotation shares one add/shift
// datapath, one step per cycle, and the three duties go through one radix-2
// divider in turn, each with a load, its shift-subtract steps and a store. An
// item that leaves the PWM off skips the rotation and the divider. The input
// stalls while an item is worked on; the result register lets the next item
// start while a result still waits, and the block holds its result until the
// register frees.
// Reset clears the trip latch, the run flag and the registers to their defaults.
// ----------------------------------------------------------------------------
module open_loop_align_pwm_with_trip #(
  parameter int unsigned CORDIC_STEPS = olapwm_pkg::CordicStepsDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // tdata: current_a_ma, current_b_ma, current_c_ma, currents_ok, clear_trip,
  //        calibrating, align_request, align_voltage_mv, align_angle
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  input  wire logic [olapwm_pkg::InDataW-1:0]       s_axis_tdata_i,
  // tdata: peak_current_ma, trip_latched, pwm_active, pwm_start_event,
  //        pwm_off_event, duty_phase_a, duty_phase_b, duty_phase_c, applied_vd_mv
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  output logic [olapwm_pkg::OutDataW-1:0]           m_axis_tdata_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [olapwm_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  wire logic [15:0]                          cfg_wdata_i
);
  import olapwm_pkg::*;

  localparam int unsigned StepsEff =
      (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
  localparam logic [IterW-1:0] IterLast = IterW'(StepsEff - 1);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivBits - 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_PRE   = 10'b0000000100,
    S_ROT   = 10'b0000001000,
    S_MUL   = 10'b0000010000,
    S_COMB  = 10'b0000100000,
    S_DLOAD = 10'b0001000000,
    S_DSTEP = 10'b0010000000,
    S_DFIN  = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_e;

  // Control registers.
  state_e        state_q, state_d;
  logic          latch_q, latch_d;
  logic          running_q, running_d;
  logic          out_valid_q, out_valid_d;
  logic [14:0]   limit_q;
  logic [15:0]   bus_q;

  // Working registers.
  in_item_t           item_q;
  res_item_t          res_q, res_d;
  res_item_t          out_q;
  logic               fold_q, fold_d;
  logic signed [31:0] x_q, x_d;
  logic signed [31:0] y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic [IterW-1:0]   iter_q, iter_d;
  logic signed [49:0] prod_q, prod_d;
  logic signed [31:0] vb_q, vb_d;
  logic signed [31:0] vc_q, vc_d;
  logic [1:0]         phase_q, phase_d;
  logic [31:0]        dvd_q, dvd_d;
  logic [15:0]        rem_q, rem_d;
  logic               neg_q, neg_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;

  // Shared multiplier.
  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [49:0] mul_p;

  // Combinational helpers.
  logic [16:0]        abs_a, abs_b, abs_c, peak;
  logic               trip_n, active;
  logic signed [12:0] vd_clamp;
  logic signed [15:0] ang_f;
  logic signed [31:0] xs, ys;
  logic signed [33:0] atan_s;
  logic signed [49:0] x_hi;
  logic signed [49:0] vb_sum, vc_sum;
  logic signed [31:0] div_op;
  logic [16:0]        rem_sh;
  logic               rem_ge;
  logic [15:0]        vbus;
  logic [15:0]        duty;

  logic in_xfer;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_q};

  // Magnitudes of the phase currents and their maximum.
  function automatic logic [16:0] mag16(input logic signed [15:0] v);
    return v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
  endfunction

  always_comb begin
    abs_a = mag16(item_q.current_a_ma);
    abs_b = mag16(item_q.current_b_ma);
    abs_c = mag16(item_q.current_c_ma);
    peak  = abs_a;
    if (abs_b > peak) peak = abs_b;
    if (abs_c > peak) peak = abs_c;
    trip_n = (item_q.clear_trip ? 1'b0 : latch_q) |
             (item_q.currents_ok && (peak > {2'b0, limit_q}));
  end

  // Voltage clamp and drive decision.
  always_comb begin
    priority if (item_q.align_voltage_mv > VdLimitMv) begin
      vd_clamp = 13'(VdLimitMv);
    end else if (item_q.align_voltage_mv < -VdLimitMv) begin
      vd_clamp = 13'(-VdLimitMv);
    end else begin
      vd_clamp = item_q.align_voltage_mv[12:0];
    end
    active = !trip_n && !item_q.calibrating && item_q.align_request &&
             (vd_clamp != 13'sd0);
  end

  // Angle folded into a quarter turn either side of zero.
  always_comb begin
    unique case (item_q.align_angle[15:14])
      2'b01, 2'b10: ang_f = {~item_q.align_angle[15], item_q.align_angle[14:0]};
      default:      ang_f = item_q.align_angle;
    endcase
  end

  // Multiplier: gain compensation first, then the sqrt(3)/2 term.
  always_comb begin
    if (state_q == S_PRE) begin
      mul_a = {{19{res_q.applied_vd_mv[12]}}, res_q.applied_vd_mv};
      mul_b = CordicGainQ16;
    end else begin
      mul_a = y_q;
      mul_b = HalfSqrt3Q16;
    end
    mul_p = mul_a * mul_b;
  end

  // CORDIC step datapath.
  always_comb begin
    xs     = x_q >>> iter_q;
    ys     = y_q >>> iter_q;
    atan_s = {4'b0, atan_turn(iter_q)};
  end

  // Inverse Clarke for phases B and C.
  always_comb begin
    x_hi   = {{3{x_q[31]}}, x_q, 15'b0};
    vb_sum = prod_q - x_hi;
    vc_sum = -x_hi - prod_q;
  end

  // Divider operand, step and duty saturation.
  always_comb begin
    vbus = (bus_q > BusFloorMv) ? bus_q : DefaultBusMv;
    unique case (phase_q)
      2'd0:    div_op = x_q;
      2'd1:    div_op = vb_q;
      default: div_op = vc_q;
    endcase
    rem_sh = {rem_q, dvd_q[31]};
    rem_ge = (rem_sh >= {1'b0, vbus});
    if (neg_q) begin
      duty = (dvd_q > 32'd32768) ? 16'd0 : 16'(32'd32768 - dvd_q);
    end else begin
      duty = (dvd_q > 32'd32767) ? 16'hFFFF : 16'(32'd32768 + dvd_q);
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    latch_d     = latch_q;
    running_d   = running_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    fold_d      = fold_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    iter_d      = iter_q;
    prod_d      = prod_q;
    vb_d        = vb_q;
    vc_d        = vc_q;
    phase_d     = phase_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    dcnt_d      = dcnt_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        latch_d               = trip_n;
        res_d.peak_current_ma = peak[15:0];
        res_d.trip_latched    = trip_n;
        res_d.pwm_active      = active;
        res_d.pwm_start_event = active && !running_q;
        res_d.pwm_off_event   = !active && running_q;
        res_d.duty_phase_a    = 16'd0;
        res_d.duty_phase_b    = 16'd0;
        res_d.duty_phase_c    = 16'd0;
        res_d.applied_vd_mv   = active ? vd_clamp : 13'sd0;
        running_d             = active;
        fold_d                = item_q.align_angle[15] ^ item_q.align_angle[14];
        state_d               = active ? S_PRE : S_WAIT;
      end
      S_PRE: begin
        x_d     = fold_q ? -mul_p[31:0] : mul_p[31:0];
        y_d     = 32'sd0;
        z_d     = {{2{ang_f[15]}}, ang_f, 16'b0};
        iter_d  = '0;
        state_d = S_ROT;
      end
      S_ROT: begin
        if (!z_q[33]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atan_s;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atan_s;
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == IterLast) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = mul_p;
        state_d = S_COMB;
      end
      S_COMB: begin
        vb_d    = vb_sum[47:16];
        vc_d    = vc_sum[47:16];
        phase_d = 2'd0;
        state_d = S_DLOAD;
      end
      S_DLOAD: begin
        neg_d   = div_op[31];
        dvd_d   = div_op[31] ? 32'(-div_op) : 32'(div_op);
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = S_DSTEP;
      end
      S_DSTEP: begin
        rem_d  = rem_ge ? 16'(rem_sh - {1'b0, vbus}) : rem_sh[15:0];
        dvd_d  = {dvd_q[30:0], rem_ge};
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DivLast) begin
          state_d = S_DFIN;
        end
      end
      S_DFIN: begin
        unique case (phase_q)
          2'd0:    res_d.duty_phase_a = duty;
          2'd1:    res_d.duty_phase_b = duty;
          default: res_d.duty_phase_c = duty;
        endcase
        if (phase_q == 2'd2) begin
          state_d = S_WAIT;
        end else begin
          phase_d = phase_q + 1'b1;
          state_d = S_DLOAD;
        end
      end
      S_WAIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      latch_q     <= 1'b0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= CurrentLimitRst;
      bus_q       <= BusVoltageRst;
    end else begin
      state_q     <= state_d;
      latch_q     <= latch_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_CURRENT_LIMIT: limit_q <= cfg_wdata_i[14:0];
          default:           bus_q   <= cfg_wdata_i;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_item_t'(s_axis_tdata_i[$bits(in_item_t)-1:0]);
    end
    if ((state_q == S_WAIT) && (!out_valid_q || m_axis_tready_i)) begin
      out_q <= res_q;
    end
    res_q  <= res_d;
    fold_q <= fold_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    iter_q <= iter_d;
    prod_q <= prod_d;
    vb_q   <= vb_d;
    vc_q   <= vc_d;
    phase_q <= phase_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    dcnt_q <= dcnt_d;
  end

  // A result never carries both a start and a safe-off event.
  a_events_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.pwm_start_event && out_q.pwm_off_event))
    else $error("start and off events in one result");

  // A result with the drive off has zero duties and zero voltage.
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.pwm_active) |->
      (out_q.duty_phase_a == 16'd0 && out_q.duty_phase_b == 16'd0 &&
       out_q.duty_phase_c == 16'd0 && out_q.applied_vd_mv == 13'sd0))
    else $error("drive off but outputs not zero");

  // The drive is never reported active while tripped.
  a_trip_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.pwm_active && out_q.trip_latched))
    else $error("drive active while tripped");

  // A result is loaded only into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i && state_q == S_WAIT) |=> state_q == S_WAIT)
    else $error("result overwritten before transfer");

endmodule
`default_nettype wire

// ----- tb/olapwm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alignment PWM result checker
// Watches the input, result and configuration channels of the alignment PWM
// stage. Every input transfer is run through a local model of the trip latch,
// the d-axis clamp, the CORDIC rotation, the inverse Clarke transform and the
// duty division. Each result transfer is compared field by field with the
// oldest predicted tick.
// ----------------------------------------------------------------------------
module olapwm_checker
  import olapwm_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  input  wire logic                s_axis_tready_i,
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  input  wire logic                m_axis_tvalid_i,
  input  wire logic                m_axis_tready_i,
  input  wire logic [OutDataW-1:0] m_axis_tdata_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [15:0]         cfg_wdata_i,
  output int                       errors_o,
  output int                       pending_o
);

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam longint AtanTurn[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // Local copy of the block's state and registers.
  logic        trip_q;
  logic        running_q;
  logic [14:0] limit_q;
  logic [15:0] bus_q;
  res_item_t   expected_ticks[$];

  assign pending_o = expected_ticks.size();

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors_o++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // Center on one half, divide by the bus voltage toward zero, saturate.
  function automatic logic [15:0] duty_from(input longint v_q16, input longint vbus);
    longint d;
    d = 32768 + v_q16 / vbus;
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return d[15:0];
  endfunction

  // One PWM tick: peak, trip latch, clamp, rotation and duties.
  function automatic res_item_t predict_tick(input in_item_t it);
    res_item_t r;
    longint ia, ib, ic, peak, vd, ang, x, y, z, xs, ys, vb, vc, vbus;
    int unsigned steps;
    logic active;
    r = '0;
    ia = it.current_a_ma;
    ib = it.current_b_ma;
    ic = it.current_c_ma;
    if (ia < 0) ia = -ia;
    if (ib < 0) ib = -ib;
    if (ic < 0) ic = -ic;
    peak = ia;
    if (ib > peak) peak = ib;
    if (ic > peak) peak = ic;

    // A clear takes effect before the over-current check of the same tick.
    if (it.clear_trip) trip_q = 1'b0;
    if (it.currents_ok && peak > longint'(limit_q)) trip_q = 1'b1;

    vd = it.align_voltage_mv;
    if (vd > 3000) vd = 3000;
    if (vd < -3000) vd = -3000;
    active = !trip_q && !it.calibrating && it.align_request && vd != 0;

    if (active) begin
      x = vd * 39797;
      y = 0;
      ang = it.align_angle;
      // Fold the angle into the quarter turns around zero.
      if (ang >= 16384 && ang < 49152) begin
        x = -x;
        ang = ang - 32768;
      end else if (ang >= 49152) begin
        ang = ang - 65536;
      end
      z = ang * 65536;
      steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
      for (int unsigned i = 0; i < steps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - AtanTurn[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + AtanTurn[i];
        end
      end
      vb = (-32768 * x + 56756 * y) >>> 16;
      vc = (-32768 * x - 56756 * y) >>> 16;
      vbus = (bus_q > 16'd1000) ? longint'(bus_q) : 24000;
      r.duty_phase_a = duty_from(x, vbus);
      r.duty_phase_b = duty_from(vb, vbus);
      r.duty_phase_c = duty_from(vc, vbus);
      r.pwm_start_event = !running_q;
      running_q = 1'b1;
    end else begin
      vd = 0;
      r.pwm_off_event = running_q;
      running_q = 1'b0;
    end

    r.peak_current_ma = peak[15:0];
    r.trip_latched = trip_q;
    r.pwm_active = active;
    r.applied_vd_mv = vd[12:0];
    return r;
  endfunction

  // Inputs and outputs only change at rising edges, so sampling on the falling
  // edge sees exactly what the next rising edge will transfer.
  always @(negedge clk_i) begin
    res_item_t got, want;
    if (!rst_ni) begin
      trip_q = 1'b0;
      running_q = 1'b0;
      limit_q = CurrentLimitRst;
      bus_q = BusVoltageRst;
      expected_ticks.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_CURRENT_LIMIT) limit_q = cfg_wdata_i[14:0];
        else if (cfg_addr_i == REG_BUS_VOLTAGE) bus_q = cfg_wdata_i;
      end
      // Result first, so a result can never match a tick accepted in the same cycle.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[$bits(res_item_t)-1:0];
        if (expected_ticks.size() == 0) begin
          report_mismatch("result transfer with no tick outstanding");
        end else begin
          want = expected_ticks.pop_front();
          check_field("peak_current_ma", got.peak_current_ma, want.peak_current_ma);
          check_field("trip_latched", got.trip_latched, want.trip_latched);
          check_field("pwm_active", got.pwm_active, want.pwm_active);
          check_field("pwm_start_event", got.pwm_start_event, want.pwm_start_event);
          check_field("pwm_off_event", got.pwm_off_event, want.pwm_off_event);
          check_field("duty_phase_a", got.duty_phase_a, want.duty_phase_a);
          check_field("duty_phase_b", got.duty_phase_b, want.duty_phase_b);
          check_field("duty_phase_c", got.duty_phase_c, want.duty_phase_c);
          check_field("applied_vd_mv", got.applied_vd_mv, want.applied_vd_mv);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_ticks.push_back(predict_tick(s_axis_tdata_i[$bits(in_item_t)-1:0]));
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alignment PWM stage testbench
// Drives PWM ticks into the stage under random back-pressure on both sides:
// a directed run over the clamp, angle folds, trip and blocking cases, then
// random ticks over several current limit and bus voltage settings. The
// checker beside the stage predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import olapwm_pkg::*;

  localparam int unsigned Steps = CordicStepsDef;
  localparam int Phases = 8;
  localparam int TicksPerPhase = 250;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tready = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = REG_CURRENT_LIMIT;
  logic [15:0]         cfg_wdata = '0;
  wire logic                s_tready;
  wire logic                m_tvalid;
  wire logic [OutDataW-1:0] m_tdata;
  int errors;
  int pending;

  // No idling on either side while set.
  logic calm = 1'b0;
  // Current limit in force, used to keep most ticks below the trip level.
  int unsigned limit_now = CurrentLimitRst;

  open_loop_align_pwm_with_trip #(.CORDIC_STEPS(Steps)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  olapwm_checker #(.CORDIC_STEPS(Steps)) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  always #5 clk_i = ~clk_i;

  // Result side back-pressure.
  always @(posedge clk_i) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 38);
  end

  function automatic in_item_t tick_item(input int ia, input int ib, input int ic,
                                         input bit ok, input bit clr, input bit cal,
                                         input bit req, input int v, input int ang);
    in_item_t it;
    it.current_a_ma = 16'(ia);
    it.current_b_ma = 16'(ib);
    it.current_c_ma = 16'(ic);
    it.currents_ok = ok;
    it.clear_trip = clr;
    it.calibrating = cal;
    it.align_request = req;
    it.align_voltage_mv = 16'(v);
    it.align_angle = 16'(ang);
    return it;
  endfunction

  // Mostly below the limit, now and then anywhere in the full range.
  function automatic int rand_current();
    int v;
    if ($urandom_range(0, 99) < 3) begin
      v = int'($signed(16'($urandom)));
    end else begin
      v = int'($urandom_range(0, limit_now));
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v;
  endfunction

  function automatic in_item_t random_tick();
    int v, ang, sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) v = int'($signed(16'($urandom)));
    else if (sel < 12) v = 0;
    else if (sel < 20) begin
      case ($urandom_range(0, 5))
        0: v = 3000;
        1: v = -3000;
        2: v = 3001;
        3: v = -3001;
        4: v = 32767;
        default: v = -32768;
      endcase
    end else v = int'($urandom_range(0, 6000)) - 3000;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 7))
        0: ang = 0;
        1: ang = 16383;
        2: ang = 16384;
        3: ang = 32767;
        4: ang = 32768;
        5: ang = 49151;
        6: ang = 49152;
        default: ang = 65535;
      endcase
    end else ang = int'($urandom_range(0, 65535));
    return tick_item(rand_current(), rand_current(), rand_current(),
                     $urandom_range(0, 99) < 88, $urandom_range(0, 99) < 15,
                     $urandom_range(0, 99) < 7, $urandom_range(0, 99) < 85, v, ang);
  endfunction

  // Entered and left at a rising edge; valid stays high unless an idle cycle follows.
  task automatic send_tick(input in_item_t it);
    if (!calm) begin
      while ($urandom_range(0, 99) < 38) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(InDataW - $bits(in_item_t)){1'b0}}, it};
    do @(negedge clk_i); while (!s_tready);
    @(posedge clk_i);
  endtask

  // Stop sending and let every outstanding result drain.
  task automatic drain_ticks();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Both registers, back to back; bit 15 of the limit write is don't-care.
  task automatic set_regs(input int unsigned limit, input int unsigned bus);
    cfg_we <= 1'b1;
    cfg_addr <= REG_CURRENT_LIMIT;
    cfg_wdata <= {1'($urandom_range(0, 1)), 15'(limit)};
    @(posedge clk_i);
    cfg_addr <= REG_BUS_VOLTAGE;
    cfg_wdata <= 16'(bus);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    limit_now = limit;
  endtask

  // Generous bound on the whole run.
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned limits[Phases];
    int unsigned buses[Phases];
    limits = '{3000, 0, 32767, 1000, 0, 500, 3000, 0};
    buses = '{0, 1000, 1001, 65535, 0, 24000, 3300, 0};
    limits[4] = $urandom_range(0, 32767);
    limits[7] = $urandom_range(0, 32767);
    buses[4] = $urandom_range(0, 65535);
    buses[7] = $urandom_range(1001, 65535);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks under the reset settings (limit 3000 mA, bus 24 V).
    send_tick(tick_item(0, 0, 0, 1, 0, 0, 0, 0, 0));
    send_tick(tick_item(10, -10, 0, 1, 0, 0, 1, 3000, 0));
    send_tick(tick_item(0, 0, 0, 1, 0, 0, 1, 32767, 16384));
    send_tick(tick_item(0, 0, 0, 1, 0, 0, 1, -32768, 49151));
    send_tick(tick_item(0, 0, 0, 1, 0, 0, 1, -3000, 49152));
    send_tick(tick_item(0, 0, 0, 1, 0, 0, 1, 1, 65535));
    send_tick(tick_item(0, 0, 0, 1, 0, 0, 1, 2999, 16383));
    send_tick(tick_item(0, 0, 0, 1, 0, 0, 1, -1, 32767));
    // Zero voltage after clamping counts as drive off.
    send_tick(tick_item(0, 0, 0, 1, 0, 0, 1, 0, 8192));
    send_tick(tick_item(0, 0, 0, 1, 0, 0, 1, 1500, 32768));
    // Calibration blocks the drive; an invalid sample never trips.
    send_tick(tick_item(32767, -32768, 32767, 0, 0, 1, 1, 1500, 100));
    send_tick(tick_item(-32768, 0, 0, 0, 0, 0, 1, 2000, 200));
    // Over-current trips and holds the drive off until cleared.
    send_tick(tick_item(-32768, 32767, -1, 1, 0, 0, 1, 2000, 300));
    send_tick(tick_item(0, 0, 0, 1, 0, 0, 1, 2000, 400));
    send_tick(tick_item(0, 0, 0, 1, 1, 0, 1, -2000, 500));
    // A clear in the same tick as an over-current leaves the trip set.
    send_tick(tick_item(0, 0, 5000, 1, 1, 0, 1, 2000, 600));
    send_tick(tick_item(3000, -3000, 3000, 1, 1, 0, 1, 2500, 40000));
    send_tick(tick_item(0, 0, -3001, 1, 0, 0, 1, 2500, 60000));
    send_tick(tick_item(0, 32767, 0, 0, 1, 1, 0, -32768, 65535));
    send_tick(tick_item(-1, -1, -1, 1, 0, 0, 1, 3000, 12345));

    // Random ticks over several register settings.
    for (int p = 0; p < Phases; p++) begin
      drain_ticks();
      set_regs(limits[p], buses[p]);
      calm = (p == 3);
      for (int n = 0; n < TicksPerPhase; n++) send_tick(random_tick());
    end
    calm = 1'b0;

    drain_ticks();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
